### design/kaf_pkg.sv
// ----------------------------------------------------------------------------
// kaf_pkg: shared types and constants for the angle/bias kalman filter
// Holds payload structs, controller states, datapath commands and helpers.
// ----------------------------------------------------------------------------
package kaf_pkg;

    localparam int unsigned W      = 32;
    localparam int unsigned DT_W   = 16;
    localparam int unsigned IDX_W  = 2;
    localparam int unsigned DIV_W  = 49;

    localparam logic [IDX_W-1:0] REG_ANGLE_NOISE   = 2'd0;
    localparam logic [IDX_W-1:0] REG_BIAS_NOISE    = 2'd1;
    localparam logic [IDX_W-1:0] REG_MEASURE_NOISE = 2'd2;

    localparam logic [W-1:0] RST_ANGLE_NOISE   = 32'd66;
    localparam logic [W-1:0] RST_BIAS_NOISE    = 32'd197;
    localparam logic [W-1:0] RST_MEASURE_NOISE = 32'd1966;

    typedef struct packed {
        logic signed [W-1:0]  meas_angle;
        logic signed [W-1:0]  meas_rate;
        logic [DT_W-1:0]      time_step;
    } t_in_beat;

    typedef struct packed {
        logic signed [W-1:0] filtered_angle;
        logic signed [W-1:0] rate_bias;
    } t_out_beat;

    // datapath micro-operations, one per controller step
    typedef enum logic [4:0] {
        OP_NOP,
        OP_RATE,      // rate = w - bias
        OP_M_ANG,     // angle += dt*rate
        OP_M_T0,      // s01 = dt*pbb
        OP_T1,        // t = s01 - pab - pba + qa
        OP_M_PAA,     // paa += dt*t, pab -= s01, pba -= s01
        OP_M_PBB,     // pbb += qb*dt
        OP_DEN,       // den = paa + qm, start k0 divide
        OP_K0,        // take k0, start k1 divide
        OP_K1,        // take k1
        OP_Y,         // y = z - angle
        OP_M_A2,      // angle += k0*y
        OP_M_B2,      // bias  += k1*y
        OP_M_C0,      // paa' = paa - k0*paa
        OP_M_C1,      // pab' = pab - k0*pab
        OP_M_C2,      // pba' = pba - k1*paa(old)
        OP_M_C3       // pbb' = pbb - k1*pab(old), commit
    } t_op;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_RUN,
        ST_DIV,
        ST_OUT
    } t_state;

    typedef struct packed {
        t_op  op;
        logic load;
    } t_cmd;

    typedef struct packed {
        logic div_busy;
    } t_status;

    function automatic logic signed [W-1:0] sat32(input logic signed [65:0] v);
        logic signed [65:0] hi;
        logic signed [65:0] lo;
        hi = 66'sd2147483647;
        lo = -66'sd2147483648;
        if (v > hi) return 32'sh7fffffff;
        else if (v < lo) return 32'sh80000000;
        else return v[W-1:0];
    endfunction

endpackage

### design/kalman_angle_filter_unit.sv
// sequence: a taken input beat passes through the predict steps, the two gain
// divides on the shared bit-serial divider and the correction steps before its result is offered
// no new beat is taken while one is in progress or its result is still waiting
// a new beat is taken in the same cycle the previous result is taken
// reset: synchronous active low, clears estimates and covariance, noise registers to defaults
// ----------------------------------------------------------------------------
// kalman_angle_filter_unit: two-state angle and gyro bias kalman filter
// Fixed point Q16.16 filter with shared multiplier and divider.
// ----------------------------------------------------------------------------
module kalman_angle_filter_unit
    import kaf_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  logic [IDX_W-1:0] i_cfg_idx,
    input  logic [W-1:0]     i_cfg_data,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  t_in_beat         i_in_data,
    output logic             o_out_valid,
    input  logic             i_out_ready,
    output t_out_beat        o_out_data
);

    logic [W-1:0] r_qa, r_qb, r_qm;
    t_cmd    cmd;
    t_status status;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_qa <= RST_ANGLE_NOISE;
            r_qb <= RST_BIAS_NOISE;
            r_qm <= RST_MEASURE_NOISE;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_ANGLE_NOISE:   r_qa <= i_cfg_data;
                REG_BIAS_NOISE:    r_qb <= i_cfg_data;
                REG_MEASURE_NOISE: r_qm <= i_cfg_data;
                default: ;
            endcase
        end
    end

    kaf_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_status    (status),
        .o_cmd       (cmd)
    );

    kaf_datapath u_dp (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cmd    (cmd),
        .i_in     (i_in_data),
        .i_qa     (r_qa),
        .i_qb     (r_qb),
        .i_qm     (r_qm),
        .o_status (status),
        .o_res    (o_out_data)
    );

    // no beat taken while a result waits unless it leaves in the same cycle
    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |-> !o_in_ready)
        else $error("input taken over pending result");

    // result stays once offered until taken
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=> (o_out_valid && $stable(o_out_data)))
        else $error("result dropped");

    // a load starts only when ready
    a_load_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.load |-> (i_in_valid && o_in_ready))
        else $error("spurious load");

endmodule

### design/kaf_div.sv
// ----------------------------------------------------------------------------
// kaf_div: signed restoring divider for gain computation
// One quotient bit per cycle, truncation toward zero, saturated to 32 bits.
// ----------------------------------------------------------------------------
module kaf_div
    import kaf_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    input  logic signed [W-1:0] i_num,
    input  logic signed [W+1:0] i_den,
    output logic                o_busy,
    output logic signed [W-1:0] o_quo
);

    logic [DIV_W-1:0] r_rem, n_rem;
    logic [DIV_W-1:0] r_quo, n_quo;
    logic [W:0]       r_den;
    logic             r_neg;
    logic             r_zero;
    logic [5:0]       r_cnt;
    logic             r_busy;
    logic [DIV_W-1:0] num_mag;
    logic [DIV_W:0]   trial;
    logic signed [W+1:0] den_c;
    logic signed [65:0] q_s;

    // magnitude of num * 2^16
    always_comb begin
        logic signed [DIV_W-1:0] nw;
        nw = {{(DIV_W-W-16){i_num[W-1]}}, i_num, 16'd0};
        num_mag = nw[DIV_W-1] ? DIV_W'(-nw) : nw;
        den_c = i_den;
    end

    // one step of long division
    always_comb begin
        trial = {r_rem, r_quo[DIV_W-1]} - {{(DIV_W-W){1'b0}}, r_den};
        if (!trial[DIV_W]) begin
            n_rem = trial[DIV_W-1:0];
            n_quo = {r_quo[DIV_W-2:0], 1'b1};
        end else begin
            n_rem = {r_rem[DIV_W-2:0], r_quo[DIV_W-1]};
            n_quo = {r_quo[DIV_W-2:0], 1'b0};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= 6'(DIV_W);
            r_rem  <= '0;
            r_quo  <= num_mag;
            r_den  <= den_c[W+1] ? (W+1)'(-den_c) : (W+1)'(den_c);
            r_neg  <= i_num[W-1] ^ den_c[W+1];
            r_zero <= (den_c == '0);
        end else if (r_busy) begin
            r_rem <= n_rem;
            r_quo <= n_quo;
            r_cnt <= r_cnt - 6'd1;
            if (r_cnt == 6'd1) r_busy <= 1'b0;
        end
    end

    // sign and saturation
    always_comb begin
        q_s = r_neg ? -$signed({17'd0, r_quo}) : $signed({17'd0, r_quo});
        o_quo = r_zero ? '0 : sat32(q_s);
    end
    assign o_busy = r_busy;

endmodule

### design/kaf_datapath.sv
// ----------------------------------------------------------------------------
// kaf_datapath: filter state, shared multiplier and gain divider
// Executes one micro-operation per controller command.
// ----------------------------------------------------------------------------
module kaf_datapath
    import kaf_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_cmd      i_cmd,
    input  t_in_beat  i_in,
    input  logic [W-1:0] i_qa,
    input  logic [W-1:0] i_qb,
    input  logic [W-1:0] i_qm,
    output t_status   o_status,
    output t_out_beat o_res
);

    logic signed [W-1:0] r_ang, r_bias, r_paa, r_pab, r_pba, r_pbb;
    logic signed [W-1:0] r_z, r_w, r_tmp, r_s01, r_k0, r_k1, r_y, r_p00, r_p01;
    logic [DT_W-1:0]     r_dt;
    logic signed [W+1:0] r_den;
    logic signed [W+1:0] den_now;
    logic                div_start;
    logic signed [W-1:0] div_num;
    logic                div_busy;
    logic signed [W-1:0] div_q;
    logic signed [W:0]   ma;
    logic signed [W:0]   mb;
    logic signed [65:0]  prod;
    logic signed [W-1:0] mq;
    logic signed [W:0]   dtx;

    assign dtx = $signed({1'b0, 16'd0, r_dt});

    // innovation variance, exact
    assign den_now = (W+2)'(r_paa) + (W+2)'($signed({1'b0, i_qm}));

    // operand select for the single multiplier
    always_comb begin
        ma = dtx;
        mb = '0;
        unique case (i_cmd.op)
            OP_M_ANG: mb = (W+1)'(r_tmp);
            OP_M_T0:  mb = (W+1)'(r_pbb);
            OP_M_PAA: mb = (W+1)'(r_tmp);
            OP_M_PBB: mb = $signed({1'b0, i_qb});
            OP_M_A2:  begin ma = (W+1)'(r_k0); mb = (W+1)'(r_y); end
            OP_M_B2:  begin ma = (W+1)'(r_k1); mb = (W+1)'(r_y); end
            OP_M_C0:  begin ma = (W+1)'(r_k0); mb = (W+1)'(r_p00); end
            OP_M_C1:  begin ma = (W+1)'(r_k0); mb = (W+1)'(r_p01); end
            OP_M_C2:  begin ma = (W+1)'(r_k1); mb = (W+1)'(r_p00); end
            OP_M_C3:  begin ma = (W+1)'(r_k1); mb = (W+1)'(r_p01); end
            default:  mb = '0;
        endcase
        prod = 66'(ma) * 66'(mb);
        mq   = sat32(prod >>> 16);
    end

    assign div_start = (i_cmd.op == OP_DEN) || (i_cmd.op == OP_K0);
    assign div_num   = (i_cmd.op == OP_DEN) ? r_paa : r_pba;

    kaf_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (div_num),
        .i_den   ((i_cmd.op == OP_DEN) ? den_now : r_den),
        .o_busy  (div_busy),
        .o_quo   (div_q)
    );

    // state and temporaries
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ang <= '0; r_bias <= '0;
            r_paa <= '0; r_pab <= '0; r_pba <= '0; r_pbb <= '0;
        end else begin
            if (i_cmd.load) begin
                r_z  <= i_in.meas_angle;
                r_w  <= i_in.meas_rate;
                r_dt <= i_in.time_step;
            end
            unique case (i_cmd.op)
                OP_RATE:  r_tmp <= sat32(66'(r_w) - 66'(r_bias));
                OP_M_ANG: r_ang <= sat32(66'(r_ang) + 66'(mq));
                OP_M_T0:  r_s01 <= mq;
                OP_T1:    r_tmp <= sat32(66'(sat32(66'(sat32(66'(r_s01) - 66'(r_pab)))
                                     - 66'(r_pba))) + $signed({34'd0, i_qa}));
                OP_M_PAA: begin
                    r_paa <= sat32(66'(r_paa) + 66'(mq));
                    r_pab <= sat32(66'(r_pab) - 66'(r_s01));
                    r_pba <= sat32(66'(r_pba) - 66'(r_s01));
                end
                OP_M_PBB: r_pbb <= sat32(66'(r_pbb) + 66'(mq));
                OP_DEN:   r_den <= den_now;
                OP_K0:    r_k0  <= div_q;
                OP_K1:    r_k1  <= div_q;
                OP_Y: begin
                    r_y   <= sat32(66'(r_z) - 66'(r_ang));
                    r_p00 <= r_paa;
                    r_p01 <= r_pab;
                end
                OP_M_A2:  r_ang  <= sat32(66'(r_ang) + 66'(mq));
                OP_M_B2:  r_bias <= sat32(66'(r_bias) + 66'(mq));
                OP_M_C0:  r_paa  <= sat32(66'(r_paa) - 66'(mq));
                OP_M_C1:  r_pab  <= sat32(66'(r_pab) - 66'(mq));
                OP_M_C2:  r_pba  <= sat32(66'(r_pba) - 66'(mq));
                OP_M_C3:  r_pbb  <= sat32(66'(r_pbb) - 66'(mq));
                default:  ;
            endcase
        end
    end

    assign o_status.div_busy = div_busy;
    assign o_res.filtered_angle = r_ang;
    assign o_res.rate_bias      = r_bias;

endmodule

### design/kaf_ctrl.sv
// ----------------------------------------------------------------------------
// kaf_ctrl: sequencer for one filter update
// Steps the datapath through predict, gain divides and correction.
// ----------------------------------------------------------------------------
module kaf_ctrl
    import kaf_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    output logic    o_in_ready,
    output logic    o_out_valid,
    input  logic    i_out_ready,
    input  t_status i_status,
    output t_cmd    o_cmd
);

    t_state r_state, n_state;
    t_op    r_op, n_op;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_op    <= OP_NOP;
        end else begin
            r_state <= n_state;
            r_op    <= n_op;
        end
    end

    // next state and commands
    always_comb begin
        n_state     = r_state;
        n_op        = r_op;
        o_cmd.op    = OP_NOP;
        o_cmd.load  = 1'b0;
        o_in_ready  = 1'b0;
        o_out_valid = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state = ST_RUN;
                    n_op = OP_RATE;
                end
            end
            ST_RUN: begin
                o_cmd.op = r_op;
                if (r_op == OP_DEN || r_op == OP_K0) begin
                    n_state = ST_DIV;
                    n_op = t_op'(r_op + 5'd1);
                end else if (r_op == OP_M_C3) begin
                    n_state = ST_OUT;
                end else begin
                    n_op = t_op'(r_op + 5'd1);
                end
            end
            ST_DIV: begin
                if (!i_status.div_busy) n_state = ST_RUN;
            end
            ST_OUT: begin
                o_out_valid = 1'b1;
                o_in_ready  = i_out_ready;
                if (i_out_ready) begin
                    if (i_in_valid) begin
                        o_cmd.load = 1'b1;
                        n_state = ST_RUN;
                        n_op = OP_RATE;
                    end else begin
                        n_state = ST_IDLE;
                    end
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

endmodule

### bench/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: regression for the angle/bias kalman filter unit
// Directed rows then random beats, each result checked against table values or
// an in-bench fixed point model, under several idling phases and noise settings.
// ----------------------------------------------------------------------------
module testbench;
    import kaf_pkg::*;

    localparam int unsigned CYCLE_LIMIT = 3000000;
    localparam int unsigned MAX_SHOWN   = 10;

    logic             i_clk;
    logic             i_rst_n;
    logic             i_cfg_we;
    logic [IDX_W-1:0] i_cfg_idx;
    logic [W-1:0]     i_cfg_data;
    logic             i_in_valid;
    logic             o_in_ready;
    t_in_beat         i_in_data;
    logic             o_out_valid;
    logic             i_out_ready;
    t_out_beat        o_out_data;

    kalman_angle_filter_unit u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in_data  (i_in_data),
        .o_out_valid(o_out_valid),
        .i_out_ready(i_out_ready),
        .o_out_data (o_out_data)
    );

    // filter model state
    logic [W-1:0]        q_angle, q_bias, r_meas;
    logic signed [W-1:0] est_angle, est_bias, p_aa, p_ab, p_ba, p_bb;

    t_out_beat estimate_q[$];
    int        mismatches = 0;
    int        cycles = 0;
    int        send_idle_pct;
    int        recv_stall_pct;
    bit        long_hold;

    function automatic logic signed [W-1:0] clamp(input longint v);
        if (v > 64'sd2147483647) return 32'sh7fffffff;
        if (v < -64'sd2147483648) return 32'sh80000000;
        return v[W-1:0];
    endfunction

    // q16.16 product, floor shift, then clamp
    function automatic logic signed [W-1:0] fx_mul(input longint a, input longint b);
        longint p;
        p = a * b;
        return clamp(p >>> 16);
    endfunction

    function automatic logic signed [W-1:0] fx_gain(input longint num, input longint den);
        if (den == 0) return '0;
        return clamp((num * 65536) / den);
    endfunction

    function automatic t_out_beat filter_update(input t_in_beat b);
        logic signed [W-1:0] rate, t, s01, k0, k1, y, o_aa, o_ab;
        longint              dt, den;
        t_out_beat           r;
        dt   = longint'(b.time_step);
        rate = clamp(longint'(b.meas_rate) - longint'(est_bias));
        est_angle = clamp(longint'(est_angle) + longint'(fx_mul(dt, rate)));
        t = clamp(longint'(fx_mul(dt, p_bb)) - longint'(p_ab));
        t = clamp(longint'(t) - longint'(p_ba));
        t = clamp(longint'(t) + longint'({32'd0, q_angle}));
        p_aa = clamp(longint'(p_aa) + longint'(fx_mul(dt, t)));
        s01  = fx_mul(dt, p_bb);
        p_ab = clamp(longint'(p_ab) - longint'(s01));
        p_ba = clamp(longint'(p_ba) - longint'(s01));
        p_bb = clamp(longint'(p_bb) + longint'(fx_mul(longint'({32'd0, q_bias}), dt)));
        den  = longint'(p_aa) + longint'({32'd0, r_meas});
        k0   = fx_gain(p_aa, den);
        k1   = fx_gain(p_ba, den);
        y    = clamp(longint'(b.meas_angle) - longint'(est_angle));
        est_angle = clamp(longint'(est_angle) + longint'(fx_mul(k0, y)));
        est_bias  = clamp(longint'(est_bias) + longint'(fx_mul(k1, y)));
        o_aa = p_aa;
        o_ab = p_ab;
        p_aa = clamp(longint'(p_aa) - longint'(fx_mul(k0, o_aa)));
        p_ab = clamp(longint'(p_ab) - longint'(fx_mul(k0, o_ab)));
        p_ba = clamp(longint'(p_ba) - longint'(fx_mul(k1, o_aa)));
        p_bb = clamp(longint'(p_bb) - longint'(fx_mul(k1, o_ab)));
        r.filtered_angle = est_angle;
        r.rate_bias      = est_bias;
        return r;
    endfunction

    // clock
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // cycle limit
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("kalman_angle_filter_unit regression: fail");
            $finish;
        end
    end

    // receiver: random stalls, plus one long hold-off counted here
    initial begin
        int hold;
        bit held;
        i_out_ready = 1'b0;
        hold = 0;
        held = 1'b0;
        forever begin
            @(posedge i_clk);
            if (long_hold && !held) begin
                hold = 3000;
                held = 1'b1;
            end
            if (hold > 0) begin
                hold--;
                i_out_ready <= 1'b0;
            end else begin
                i_out_ready <= ($urandom_range(99) >= recv_stall_pct);
            end
        end
    end

    // result checker
    always @(posedge i_clk) begin
        t_out_beat want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (estimate_q.size() == 0) begin
                mismatches++;
                if (mismatches <= MAX_SHOWN)
                    $display("unexpected result beat %h", o_out_data);
            end else begin
                want = estimate_q.pop_front();
                if (want.filtered_angle !== o_out_data.filtered_angle ||
                    want.rate_bias !== o_out_data.rate_bias) begin
                    mismatches++;
                    if (mismatches <= MAX_SHOWN)
                        $display("mismatch: angle exp %h got %h, bias exp %h got %h",
                                 want.filtered_angle, o_out_data.filtered_angle,
                                 want.rate_bias, o_out_data.rate_bias);
                end
            end
        end
    end

    // register write while idle, model follows
    task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [W-1:0] val);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            REG_ANGLE_NOISE:   q_angle = val;
            REG_BIAS_NOISE:    q_bias  = val;
            REG_MEASURE_NOISE: r_meas  = val;
            default: ;
        endcase
        @(posedge i_clk);
    endtask

    // offer one beat, hold until taken; valid stays up for a following beat
    task automatic send_beat(input t_in_beat b);
        if ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < send_idle_pct);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= b;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        estimate_q.push_back(filter_update(b));
    endtask

    task automatic drain();
        i_in_valid <= 1'b0;
        while (estimate_q.size() != 0) @(posedge i_clk);
        repeat (150) @(posedge i_clk);
    endtask

    function automatic t_in_beat random_beat();
        t_in_beat b;
        int       mode;
        mode = $urandom_range(9);
        b.meas_angle = (mode < 6) ? $signed($urandom_range(2*65536*360)) - 65536*360
                                  : $signed($urandom());
        b.meas_rate  = (mode < 6) ? $signed($urandom_range(2*65536*500)) - 65536*500
                                  : $signed($urandom());
        b.time_step  = (mode < 7) ? 16'($urandom_range(1000)) : 16'($urandom());
        return b;
    endfunction

    typedef struct {
        t_in_beat  beat;
        bit        known;
        t_out_beat want;
    } t_row;

    initial begin
        t_row      rows[$];
        int        phase;
        i_rst_n = 1'b0; i_cfg_we = 1'b0; i_cfg_idx = '0; i_cfg_data = '0;
        i_in_valid = 1'b0; i_in_data = '0;
        send_idle_pct = 0; recv_stall_pct = 0;
        long_hold = 1'b0;
        q_angle = RST_ANGLE_NOISE; q_bias = RST_BIAS_NOISE; r_meas = RST_MEASURE_NOISE;
        est_angle = '0; est_bias = '0; p_aa = '0; p_ab = '0; p_ba = '0; p_bb = '0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed table: first row after reset with zero measure noise gives
        // zero denominator, so zero gains and zero outputs
        write_reg(REG_MEASURE_NOISE, '0);
        write_reg(REG_ANGLE_NOISE, '0);
        rows.push_back('{'{32'sh7fffffff, 32'sh7fffffff, 16'd0}, 1, '{0, 0}});
        rows.push_back('{'{32'sh80000000, 32'sh80000000, 16'd0}, 1, '{0, 0}});
        foreach (rows[i]) begin
            void'(filter_update(rows[i].beat));
            estimate_q.push_back(rows[i].want);
            i_in_valid <= 1'b1; i_in_data <= rows[i].beat;
            @(posedge i_clk);
            while (!o_in_ready) @(posedge i_clk);
        end
        drain();
        write_reg(REG_ANGLE_NOISE, RST_ANGLE_NOISE);
        write_reg(REG_MEASURE_NOISE, RST_MEASURE_NOISE);
        rows.delete();
        rows.push_back('{'{32'sh7fffffff, 32'sh7fffffff, 16'hffff}, 0, '{0, 0}});
        rows.push_back('{'{32'sh80000000, 32'sh80000000, 16'hffff}, 0, '{0, 0}});
        rows.push_back('{'{32'sh00010000, 32'sh00000000, 16'd0}, 0, '{0, 0}});
        rows.push_back('{'{32'sh00000000, 32'sh00640000, 16'd655}, 0, '{0, 0}});
        rows.push_back('{'{32'shffff0000, 32'shffffffff, 16'd1}, 0, '{0, 0}});
        rows.push_back('{'{32'sh00000000, 32'sh00000000, 16'd0}, 0, '{0, 0}});
        foreach (rows[i]) send_beat(rows[i].beat);
        drain();

        // extreme noise settings: large noise gives saturation, den stays positive
        write_reg(REG_ANGLE_NOISE, 32'hffffffff);
        write_reg(REG_BIAS_NOISE, 32'hffffffff);
        write_reg(REG_MEASURE_NOISE, 32'hffffffff);
        for (int i = 0; i < 12; i++) send_beat(random_beat());
        drain();

        // random phases with different idling and settings
        for (phase = 0; phase < 6; phase++) begin
            case (phase)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 81; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 81; end
                3: begin send_idle_pct = 6;  recv_stall_pct = 6;  end
                4: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                default: begin send_idle_pct = 30; recv_stall_pct = 30; end
            endcase
            write_reg(REG_ANGLE_NOISE, (phase == 4) ? 32'd0 : 32'($urandom_range(70000)));
            write_reg(REG_BIAS_NOISE, (phase == 4) ? 32'd0 : 32'($urandom_range(70000)));
            write_reg(REG_MEASURE_NOISE, (phase == 5) ? $urandom()
                                                       : 32'($urandom_range(70000)));
            if (phase == 3) long_hold = 1'b1;
            for (int i = 0; i < 235; i++) begin
                if (phase == 3 && i == 3) long_hold = 1'b0;
                send_beat(random_beat());
                // sender waits for everything outstanding once per phase
                if (i == 100) begin
                    i_in_valid <= 1'b0;
                    while (estimate_q.size() != 0) @(posedge i_clk);
                end
            end
            drain();
        end

        if (mismatches == 0 && estimate_q.size() == 0)
            $display("kalman_angle_filter_unit regression: pass");
        else
            $display("kalman_angle_filter_unit regression: fail");
        $finish;
    end

endmodule
